>>> design/rkeq_pkg.sv
// Shared types, constants and control interfaces for the resonant kernel FIR equalizer.
package rkeq_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int CHAN_BITS    = 4;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int COEF_BITS    = 24;
  localparam int CORDIC_STEPS = 18;
  localparam int CSTEP_W      = 5;
  localparam int CORDIC_W     = 24;
  localparam int ANG_W        = 32;
  localparam int Z_W          = 34;

  localparam logic [CFG_BITS-1:0] RESO_MIN  = 16'd655;
  localparam logic [CFG_BITS-1:0] RESO_MAX  = 16'd64880;
  localparam logic [CFG_BITS-1:0] SCALE_MIN = 16'd1;
  localparam logic [CFG_BITS-1:0] SCALE_RST = 16'd32768;

  localparam logic [18:0] HALF_PI_Q18 = 19'd411775;
  localparam logic [16:0] TWENTY_PCT  = 17'd13107;
  localparam logic [27:0] RAD_TO_ANG  = 28'd170891319;
  localparam logic [25:0] FALL_STEP   = 26'd35790647;

  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 24'sd636752;

  localparam logic [30:0] ATAN_TAB [CORDIC_STEPS] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
    31'd21354465, 31'd10679839, 31'd5340245, 31'd2670163, 31'd1335087,
    31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722,
    31'd20861, 31'd10430, 31'd5215
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESO_ONE   = 3'd0,
    REG_RESO_TWO   = 3'd1,
    REG_RESO_THREE = 3'd2,
    REG_RESO_FOUR  = 3'd3,
    REG_INV_RATE   = 3'd4,
    REG_WET_MIX    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          chan;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0]          chan_out;
    logic signed [SAMPLE_BITS-1:0] sample_out;
  } out_item_t;

  typedef struct packed {
    logic clr_step;
    logic cap_in;
    logic mod_step;
    logic fc_rd;
    logic fc_wr;
    logic fall_ang;
    logic cordic_load;
    logic cordic_step;
    logic fall_cap;
    logic beam_sq;
    logic beam_ph;
    logic beam_ang;
    logic beam_prod;
    logic beam_term;
    logic beam_acc;
    logic beam_next;
    logic kern_wr;
    logic mac_issue;
    logic dly_wr;
    logic div_pre;
    logic div_step;
    logic mix;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic chan_ok;
    logic cordic_last;
    logic beam_on;
    logic beam_last;
    logic mac_last;
    logic mac_busy;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> design/resonant_kernel_fir_eq_core.sv
// Top level of the per-channel resonant-kernel FIR equalizer.
// One item at a time: input stays stalled from capture until the result is loaded into
// the output register; an out-of-range chan has CHANNELS subtracted until in range.
// Each item uses the shared CORDIC and the single MAC in turn; idle beams are skipped.
// Reset clears all CHANNELS*TAPS entries (944 by default) of the kernel and
// delay memories, with input stalled; config writes are taken throughout.
module resonant_kernel_fir_eq_core import rkeq_pkg::*; #(
  parameter int CHANNELS = 16,
  parameter int TAPS     = 59
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  assign cfg_ready = 1'b1;

  rkeq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  rkeq_dp #(.CHANNELS(CHANNELS), .TAPS(TAPS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> design/rkeq_ram.sv
// Generic single-port RAM with registered read.
module rkeq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 944
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/rkeq_ctrl.sv
// Sequencer: runs the reset clear, then steps each item through kernel update, MAC, divide and mix.
module rkeq_ctrl import rkeq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  typedef enum logic [24:0] {
    S_CLEAR    = 25'd1 << 0,
    S_IDLE     = 25'd1 << 1,
    S_MOD      = 25'd1 << 2,
    S_FC_RD    = 25'd1 << 3,
    S_FC_WR    = 25'd1 << 4,
    S_FALL_ANG = 25'd1 << 5,
    S_FALL_LD  = 25'd1 << 6,
    S_FALL_RUN = 25'd1 << 7,
    S_FALL_CAP = 25'd1 << 8,
    S_B_SQ     = 25'd1 << 9,
    S_B_PH     = 25'd1 << 10,
    S_B_ANG    = 25'd1 << 11,
    S_B_LD     = 25'd1 << 12,
    S_B_RUN    = 25'd1 << 13,
    S_B_PROD   = 25'd1 << 14,
    S_B_TERM   = 25'd1 << 15,
    S_B_ACC    = 25'd1 << 16,
    S_KW       = 25'd1 << 17,
    S_MAC      = 25'd1 << 18,
    S_DRAIN    = 25'd1 << 19,
    S_DWR      = 25'd1 << 20,
    S_DIV_PRE  = 25'd1 << 21,
    S_DIV      = 25'd1 << 22,
    S_MIX      = 25'd1 << 23,
    S_OUT      = 25'd1 << 24
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_MOD;
        end
      end
      S_MOD: begin
        if (st.chan_ok) state_nxt = S_FC_RD;
        else cmd.mod_step = 1'b1;
      end
      S_FC_RD: begin
        cmd.fc_rd = 1'b1;
        state_nxt = S_FC_WR;
      end
      S_FC_WR: begin
        cmd.fc_wr = 1'b1;
        state_nxt = S_FALL_ANG;
      end
      S_FALL_ANG: begin
        cmd.fall_ang = 1'b1;
        state_nxt    = S_FALL_LD;
      end
      S_FALL_LD: begin
        cmd.cordic_load = 1'b1;
        state_nxt       = S_FALL_RUN;
      end
      S_FALL_RUN: begin
        cmd.cordic_step = 1'b1;
        if (st.cordic_last) state_nxt = S_FALL_CAP;
      end
      S_FALL_CAP: begin
        cmd.fall_cap = 1'b1;
        state_nxt    = S_B_SQ;
      end
      S_B_SQ: begin
        if (st.beam_on) begin
          cmd.beam_sq = 1'b1;
          state_nxt   = S_B_PH;
        end else begin
          // beam parked at minimum resonance contributes nothing
          cmd.beam_next = 1'b1;
          if (st.beam_last) state_nxt = S_KW;
        end
      end
      S_B_PH: begin
        cmd.beam_ph = 1'b1;
        state_nxt   = S_B_ANG;
      end
      S_B_ANG: begin
        cmd.beam_ang = 1'b1;
        state_nxt    = S_B_LD;
      end
      S_B_LD: begin
        cmd.cordic_load = 1'b1;
        state_nxt       = S_B_RUN;
      end
      S_B_RUN: begin
        cmd.cordic_step = 1'b1;
        if (st.cordic_last) state_nxt = S_B_PROD;
      end
      S_B_PROD: begin
        cmd.beam_prod = 1'b1;
        state_nxt     = S_B_TERM;
      end
      S_B_TERM: begin
        cmd.beam_term = 1'b1;
        state_nxt     = S_B_ACC;
      end
      S_B_ACC: begin
        cmd.beam_acc  = 1'b1;
        cmd.beam_next = 1'b1;
        state_nxt     = st.beam_last ? S_KW : S_B_SQ;
      end
      S_KW: begin
        cmd.kern_wr = 1'b1;
        state_nxt   = S_MAC;
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (st.mac_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!st.mac_busy) state_nxt = S_DWR;
      end
      S_DWR: begin
        cmd.dly_wr = 1'b1;
        state_nxt  = S_DIV_PRE;
      end
      S_DIV_PRE: begin
        cmd.div_pre = 1'b1;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_MIX;
      end
      S_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/rkeq_dp.sv
// Datapath: config registers, CORDIC, kernel arithmetic, MAC, divide-by-3 and mix.
module rkeq_dp import rkeq_pkg::*; #(
  parameter int CHANNELS = 16,
  parameter int TAPS     = 59
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             st,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_wdata,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_item_t            out_data
);

  localparam int DEPTH  = CHANNELS * TAPS;
  localparam int MAW    = $clog2(DEPTH);
  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KW     = $clog2(TAPS);
  localparam int NW     = $clog2(TAPS + 1);
  localparam int PW     = NW + 18;
  localparam int AMW    = PW + 29;
  localparam int TF_W   = 2 * CORDIC_W;
  localparam int T_W    = TF_W - 19;
  localparam int TERM_W = T_W + 19;
  localparam int SUM_W  = TERM_W + 2;
  localparam int RQ_W   = SUM_W - 17;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam int QW     = ACC_W - 20;
  localparam int YM_W   = QW + 17;
  localparam int XM_W   = SAMPLE_BITS + 18;
  localparam int MXW    = QW + 18;
  localparam int OW     = MXW - 16;

  localparam logic signed [RQ_W-1:0] COEF_HI = RQ_W'((1 << (COEF_BITS - 1)) - 1);
  localparam logic signed [RQ_W-1:0] COEF_LO = -RQ_W'(1 << (COEF_BITS - 1));
  localparam logic signed [OW-1:0]   OUT_HI  = OW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [OW-1:0]   OUT_LO  = -OW'(1 << (SAMPLE_BITS - 1));

  function automatic logic [CFG_BITS-1:0] clamp_reso(input logic [CFG_BITS-1:0] v);
    logic [CFG_BITS-1:0] r;
    r = v;
    if (v < RESO_MIN) r = RESO_MIN;
    if (v > RESO_MAX) r = RESO_MAX;
    return r;
  endfunction

  // configuration
  logic [CFG_BITS-1:0] reso_r [4];
  logic [CFG_BITS-1:0] scale_r;
  logic [CFG_BITS-1:0] wet_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reso_r[0] <= RESO_MIN;
      reso_r[1] <= RESO_MIN;
      reso_r[2] <= RESO_MIN;
      reso_r[3] <= RESO_MIN;
      scale_r   <= SCALE_RST;
      wet_r     <= RESO_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESO_ONE:   reso_r[0] <= cfg_wdata;
        REG_RESO_TWO:   reso_r[1] <= cfg_wdata;
        REG_RESO_THREE: reso_r[2] <= cfg_wdata;
        REG_RESO_FOUR:  reso_r[3] <= cfg_wdata;
        REG_INV_RATE:   scale_r   <= cfg_wdata;
        REG_WET_MIX:    wet_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // item and channel
  in_item_t             in_r;
  logic [CHAN_BITS-1:0] chan_r;
  logic [CW-1:0]        chan_idx;
  logic [MAW-1:0]       base_r;
  logic [NW-1:0]        n_r;
  logic [NW-1:0]        n_nxt;
  logic [MAW-1:0]       clr_cnt_r;
  logic [MAW-1:0]       wr_addr;

  assign chan_idx = CW'(chan_r);
  assign wr_addr  = base_r + MAW'(n_r) - MAW'(1);

  // memories
  logic                  fc_we;
  logic [CW-1:0]         fc_addr;
  logic [NW-1:0]         fc_wdata;
  logic [NW-1:0]         fc_rdata;
  logic                  ker_we;
  logic [MAW-1:0]        ker_addr;
  logic [COEF_BITS-1:0]  ker_wdata;
  logic [COEF_BITS-1:0]  ker_rdata;
  logic                  dly_we;
  logic [MAW-1:0]        dly_addr;
  logic [SAMPLE_BITS-1:0] dly_wdata;
  logic [SAMPLE_BITS-1:0] dly_rdata;

  logic [KW-1:0]         k_r;
  logic [KW-1:0]         dslot_r;
  logic signed [COEF_BITS-1:0] coef;

  assign n_nxt = (fc_rdata >= NW'(TAPS)) ? NW'(1) : fc_rdata + NW'(1);

  always_comb begin
    fc_we    = 1'b0;
    fc_addr  = chan_idx;
    fc_wdata = n_nxt;
    if (cmd.clr_step) begin
      fc_we    = (clr_cnt_r < MAW'(CHANNELS));
      fc_addr  = CW'(clr_cnt_r);
      fc_wdata = NW'(1);
    end else if (cmd.fc_wr) begin
      fc_we = 1'b1;
    end
  end

  always_comb begin
    ker_we    = cmd.clr_step | cmd.kern_wr;
    ker_wdata = cmd.clr_step ? '0 : coef;
    if (cmd.clr_step) ker_addr = clr_cnt_r;
    else if (cmd.kern_wr) ker_addr = wr_addr;
    else ker_addr = base_r + MAW'(k_r);
    dly_we    = cmd.clr_step | cmd.dly_wr;
    dly_wdata = cmd.clr_step ? '0 : in_r.sample_in;
    if (cmd.clr_step) dly_addr = clr_cnt_r;
    else if (cmd.dly_wr) dly_addr = wr_addr;
    else dly_addr = base_r + MAW'(dslot_r);
  end

  rkeq_ram #(.WIDTH(NW), .DEPTH(CHANNELS)) u_fc_ram (
    .clk(clk), .we(fc_we), .addr(fc_addr), .wdata(fc_wdata), .rdata(fc_rdata)
  );

  rkeq_ram #(.WIDTH(COEF_BITS), .DEPTH(DEPTH)) u_ker_ram (
    .clk(clk), .we(ker_we), .addr(ker_addr), .wdata(ker_wdata), .rdata(ker_rdata)
  );

  rkeq_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_dly_ram (
    .clk(clk), .we(dly_we), .addr(dly_addr), .wdata(dly_wdata), .rdata(dly_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + MAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r   <= in_data;
      chan_r <= in_data.chan;
    end
    if (cmd.mod_step) chan_r <= chan_r - CHAN_BITS'(CHANNELS);
    if (cmd.fc_rd) base_r <= MAW'(chan_idx) * MAW'(TAPS);
    if (cmd.fc_wr) n_r <= n_nxt;
  end

  // shared CORDIC, one micro-rotation per cycle
  logic [ANG_W-1:0]           ang_r;
  logic signed [CORDIC_W-1:0] cx_r, cy_r;
  logic signed [Z_W-1:0]      cz_r;
  logic                       cneg_r;
  logic [CSTEP_W-1:0]         cstep_r;
  logic                       fold;
  logic [ANG_W-1:0]           ang_f;
  logic signed [CORDIC_W-1:0] sx, sy, sin_v, cos_v;
  logic [Z_W-1:0]             atan_v;

  assign fold   = ang_r[ANG_W-1] ^ ang_r[ANG_W-2];
  assign ang_f  = fold ? {~ang_r[ANG_W-1], ang_r[ANG_W-2:0]} : ang_r;
  assign sx     = cx_r >>> cstep_r;
  assign sy     = cy_r >>> cstep_r;
  assign atan_v = Z_W'(ATAN_TAB[cstep_r]);
  assign sin_v  = cneg_r ? -cy_r : cy_r;
  assign cos_v  = cneg_r ? -cx_r : cx_r;

  always_ff @(posedge clk) begin
    if (cmd.cordic_load) begin
      cx_r    <= CORDIC_X0;
      cy_r    <= '0;
      cz_r    <= {{(Z_W - ANG_W){ang_f[ANG_W-1]}}, ang_f};
      cneg_r  <= fold;
      cstep_r <= '0;
    end else if (cmd.cordic_step) begin
      if (!cz_r[Z_W-1]) begin
        cx_r <= cx_r - sy;
        cy_r <= cy_r + sx;
        cz_r <= cz_r - atan_v;
      end else begin
        cx_r <= cx_r + sy;
        cy_r <= cy_r - sx;
        cz_r <= cz_r + atan_v;
      end
      cstep_r <= cstep_r + CSTEP_W'(1);
    end
  end

  // kernel coefficient
  logic [1:0]                 beam_r;
  logic [CFG_BITS-1:0]        r_cl;
  logic [CFG_BITS-1:0]        scale_cl;
  logic [31:0]                sq_r;
  logic [33:0]                vp_r;
  logic [17:0]                v_r;
  logic [PW-1:0]              p_r;
  logic                       sel_r;
  logic signed [CORDIC_W-1:0] fall_r;
  logic signed [TF_W-1:0]     tf_r;
  logic signed [TERM_W-1:0]   term_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [32:0]                fb_sum;
  logic [34:0]                v_sum;
  logic                       lt_half;
  logic [PW:0]                pp;
  logic [AMW-1:0]             amul;
  logic signed [CORDIC_W-1:0] trig;
  logic signed [TF_W:0]       t_sum;
  logic signed [T_W-1:0]      t_v;
  logic signed [SUM_W-1:0]    rsum;
  logic signed [RQ_W-1:0]     rq;

  assign r_cl     = clamp_reso(reso_r[beam_r]);
  assign scale_cl = (scale_r < SCALE_MIN) ? SCALE_MIN : scale_r;
  assign fb_sum   = 33'(sq_r) + 33'd8192;
  assign v_sum    = 35'(vp_r) + 35'd16384;
  assign lt_half  = (p_r < PW'(HALF_PI_Q18));
  assign pp       = lt_half ? {p_r, 1'b0} : {1'b0, p_r};
  assign amul     = AMW'(pp) * AMW'(RAD_TO_ANG) + AMW'(32768);
  assign trig     = sel_r ? sin_v : cos_v;
  assign t_sum    = (TF_W+1)'(tf_r) + (TF_W+1)'(524288);
  assign t_v      = t_sum[TF_W:20];
  assign rsum     = sum_r + SUM_W'(65536);
  assign rq       = rsum[SUM_W-1:17];

  always_comb begin
    coef = rq[COEF_BITS-1:0];
    if (rq > COEF_HI) coef = COEF_HI[COEF_BITS-1:0];
    if (rq < COEF_LO) coef = COEF_LO[COEF_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.fall_ang) ang_r <= ANG_W'(ANG_W'(n_r) * ANG_W'(FALL_STEP));
    if (cmd.beam_ang) begin
      ang_r <= amul[47:16];
      sel_r <= lt_half;
    end
    if (cmd.fall_cap) begin
      fall_r <= sin_v;
      sum_r  <= '0;
    end
    if (cmd.beam_sq) begin
      sq_r <= 32'(r_cl) * 32'(r_cl);
      vp_r <= 34'(17'(r_cl) + TWENTY_PCT) * 34'(scale_cl);
    end
    if (cmd.beam_ph) begin
      p_r <= PW'(n_r) * PW'(fb_sum[31:14]);
      v_r <= v_sum[32:15];
    end
    if (cmd.beam_prod) tf_r <= trig * fall_r;
    if (cmd.beam_term) term_r <= t_v * $signed({1'b0, v_r});
    if (cmd.beam_acc) sum_r <= sum_r + SUM_W'(term_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.fall_cap) begin
      beam_r <= '0;
    end else if (cmd.beam_next) begin
      beam_r <= beam_r + 2'd1;
    end
  end

  // MAC over the channel's taps; delay slot walks backward from the newest sample
  logic                     rd_v_r, mul_v_r;
  logic signed [PROD_W-1:0] mprod_r;
  logic signed [ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (cmd.kern_wr) begin
      k_r     <= '0;
      dslot_r <= (n_r >= NW'(2)) ? KW'(n_r - NW'(2)) : KW'(TAPS - 1);
    end else if (cmd.mac_issue) begin
      k_r     <= k_r + KW'(1);
      dslot_r <= (dslot_r == '0) ? KW'(TAPS - 1) : dslot_r - KW'(1);
    end
    if (rd_v_r) mprod_r <= $signed(dly_rdata) * $signed(ker_rdata);
    if (cmd.kern_wr) acc_r <= '0;
    else if (mul_v_r) acc_r <= acc_r + ACC_W'(mprod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.mac_issue;
      mul_v_r <= rd_v_r;
    end
  end

  // divide by 3*2^21: add 3*2^20, shift out 2^21, then floor-divide by 3 via the magnitude.
  // q = qh*2^17 + ql with 2^17 = 3*43690 + 2, so q/3 = qh*43690 + (2*qh + ql)/3;
  // the small quotient is a reciprocal multiply, exact below 2^21.
  localparam int QH_W = QW - 17;
  localparam int XW   = ((QH_W > 17) ? QH_W : 17) + 2;
  localparam logic [19:0] RECIP3 = 20'd699051;

  logic signed [ACC_W:0] q_sum;
  logic [QW-1:0]         q4;
  logic                  neg_r;
  logic [QW-1:0]         qd_r;
  logic [QW-1:0]         qhi_r;
  logic [XW-1:0]         qlo_r;
  logic                  dcnt_r;
  logic [XW-1:0]         xs;
  logic [XW+19:0]        xq;

  assign q_sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(3 << 20);
  assign q4    = q_sum[ACC_W:21];
  assign xs    = XW'({qd_r[QW-1:17], 1'b0}) + XW'(qd_r[16:0]);
  assign xq    = (XW+20)'(xs) * (XW+20)'(RECIP3);

  always_ff @(posedge clk) begin
    if (cmd.div_pre) begin
      neg_r  <= q4[QW-1];
      qd_r   <= q4[QW-1] ? (~q4 + QW'(3)) : q4;
      dcnt_r <= 1'b0;
    end else if (cmd.div_step) begin
      if (!dcnt_r) begin
        qhi_r <= QW'(qd_r[QW-1:17]) * QW'(16'd43690);
        qlo_r <= XW'(xq[XW+19:21]);
      end else begin
        qd_r <= qhi_r + QW'(qlo_r);
      end
      dcnt_r <= 1'b1;
    end
  end

  // dry/wet mix
  logic [CFG_BITS-1:0]    wet_cl;
  logic [16:0]            dry_w;
  logic signed [QW-1:0]   yq;
  logic signed [YM_W-1:0] ym_r;
  logic signed [XM_W-1:0] xm_r;
  logic signed [MXW-1:0]  m_sum;
  logic signed [OW-1:0]   o_v;
  logic signed [SAMPLE_BITS-1:0] o_sat;

  assign wet_cl = clamp_reso(wet_r);
  assign dry_w  = 17'd65536 - 17'(wet_cl);
  assign yq     = neg_r ? -qd_r : qd_r;
  assign m_sum  = MXW'(ym_r) + MXW'(xm_r) + MXW'(32768);
  assign o_v    = m_sum[MXW-1:16];

  always_comb begin
    o_sat = o_v[SAMPLE_BITS-1:0];
    if (o_v > OUT_HI) o_sat = OUT_HI[SAMPLE_BITS-1:0];
    if (o_v < OUT_LO) o_sat = OUT_LO[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      ym_r <= yq * $signed({1'b0, wet_cl});
      xm_r <= in_r.sample_in * $signed({1'b0, dry_w});
    end
    if (cmd.out_load) begin
      out_data.chan_out   <= in_r.chan;
      out_data.sample_out <= o_sat;
    end
  end

  // output register: next item may start while this transfer waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    st.clr_last    = (clr_cnt_r == MAW'(DEPTH - 1));
    st.chan_ok     = (7'(chan_r) < 7'(CHANNELS));
    st.cordic_last = (cstep_r == CSTEP_W'(CORDIC_STEPS - 1));
    st.beam_on     = (r_cl > RESO_MIN);
    st.beam_last   = (beam_r == 2'd3);
    st.mac_last    = (k_r == KW'(TAPS - 1));
    st.mac_busy    = rd_v_r | mul_v_r;
    st.div_last    = dcnt_r;
    st.out_free    = !out_valid || !out_stall;
  end

endmodule
